// File: rtl/core/hmtri_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the heightmap triangle height query block.
// No dependencies.
package hmtri_pkg;

  localparam int FUNC_W   = 1;
  localparam int VERT_W   = 7;
  localparam int SAMPLE_W = 8;
  localparam int POS_W    = 14;
  localparam int SCALE_W  = 16;
  localparam int HEIGHT_W = 16;
  localparam int BANKS    = 4;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3277;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

endpackage

// File: rtl/core/hmtri_if.sv
`timescale 1ns / 1ps
// Channel interfaces: command items in, height results out, scale register writes.
// Depends on hmtri_pkg.
interface hmtri_cmd_if;
  import hmtri_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0]   func;
  logic [VERT_W-1:0]   vert_col;
  logic [VERT_W-1:0]   vert_row;
  logic [SAMPLE_W-1:0] height_sample;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_z;

  modport source (output valid, func, vert_col, vert_row, height_sample, pos_x, pos_z,
                  input ready);
  modport sink   (input valid, func, vert_col, vert_row, height_sample, pos_x, pos_z,
                  output ready);
endinterface

interface hmtri_rsp_if;
  import hmtri_pkg::*;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  logic                lower_triangle;

  modport source (output valid, height, lower_triangle, input ready);
  modport sink   (input valid, height, lower_triangle, output ready);
endinterface

interface hmtri_cfg_if;
  import hmtri_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/hmtri_store.sv
`timescale 1ns / 1ps
// Sample store split into four banks by row and column parity, so the four
// corners of any cell come from distinct banks. Depends on hmtri_pkg.
module hmtri_store #(
  parameter int GRID_CELLS  = 64,
  parameter int SAMPLE_BITS = 8,
  parameter int BANK_SIDE   = GRID_CELLS / 2 + 1,
  parameter int AW          = $clog2(BANK_SIDE * BANK_SIDE)
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [1:0]                           wr_bank,
  input  logic [AW-1:0]                        wr_addr,
  input  logic [SAMPLE_BITS-1:0]               wr_data,
  input  logic                                 rd_en,
  input  logic [hmtri_pkg::BANKS-1:0][AW-1:0]          rd_addr,
  output logic [hmtri_pkg::BANKS-1:0][SAMPLE_BITS-1:0] rd_data
);
  import hmtri_pkg::*;

  localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [SAMPLE_BITS-1:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data[b] <= mem[rd_addr[b]];
      end
    end
  end

endmodule

// File: rtl/core/heightmap_triangle_height_query.sv
`timescale 1ns / 1ps
// Heightmap triangle height query: top level with the five-stage query pipeline.
// Depends on hmtri_pkg, hmtri_if and hmtri_store.

// One item per cycle in both directions while the output side keeps up. A write
// item updates the sample store on the edge it is accepted and gives no result.
// A query item passes one register stage each for the store read, the two corner
// products, the sum, the scale product and the rounded output. The store is four
// banks split by row and column parity, each with one write and one read port, so
// all four corners of a cell are read in the same cycle as any write. Samples are
// undefined until written and there is no clearing pass. A stall holds the
// pipeline without loss, and empty stages still fill while a result waits. Scale
// register writes are always taken and should only be issued with no queries in
// flight.
module heightmap_triangle_height_query #(
  parameter int GRID_CELLS  = 64,
  parameter int FRAC_BITS   = 8,
  parameter int SAMPLE_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  hmtri_cmd_if.sink   cmd,
  hmtri_rsp_if.source rsp,
  hmtri_cfg_if.sink   cfg
);
  import hmtri_pkg::*;

  localparam int SW        = SAMPLE_BITS;
  localparam int FW        = FRAC_BITS + 1;
  localparam int CELL_W    = $clog2(GRID_CELLS);
  localparam int BANK_SIDE = GRID_CELLS / 2 + 1;
  localparam int HALF_W    = $clog2(BANK_SIDE);
  localparam int AW        = $clog2(BANK_SIDE * BANK_SIDE);
  localparam int P_W       = SW + FW + 2;
  localparam int H_W       = P_W + 2;
  localparam int HU        = SW + FRAC_BITS;
  localparam logic [31:0]   LIMIT    = 32'(GRID_CELLS) << FRAC_BITS;
  localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic [CELL_W+FW-1:0] split_pos(input logic [POS_W-1:0] p);
    logic [31:0] pc;
    logic [31:0] ip;
    pc = (32'(p) > LIMIT) ? LIMIT : 32'(p);
    ip = pc >> FRAC_BITS;
    if (ip >= 32'(GRID_CELLS)) begin
      return {CELL_W'(GRID_CELLS - 1), FRAC_ONE};
    end
    return {ip[CELL_W-1:0], 1'b0, pc[FRAC_BITS-1:0]};
  endfunction

  function automatic logic [AW-1:0] bank_addr(input logic [HALF_W-1:0] rh,
                                              input logic [HALF_W-1:0] ch);
    return AW'(32'(rh) * BANK_SIDE + 32'(ch));
  endfunction

  // stage handshake
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !s5_valid || rsp.ready;
  assign adv4 = !s4_valid || adv5;
  assign adv3 = !s3_valid || adv4;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;

  assign cmd.ready = adv1;

  logic cmd_take;
  logic is_query;
  assign cmd_take = cmd.valid && cmd.ready;
  assign is_query = (cmd.func == FUNC_QUERY);

  // scale register
  logic [SCALE_W-1:0] scale;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg.valid) begin
      scale <= cfg.data;
    end
  end

  // stage 0: clamp, split, bank addresses
  logic [CELL_W-1:0] cx, cz;
  logic [FW-1:0]     fx, fz;
  logic [FW:0]       fsum;
  logic [HALF_W-1:0] col_half [2];
  logic [HALF_W-1:0] row_half [2];
  logic [BANKS-1:0][AW-1:0] rd_addr;

  always_comb begin
    {cx, fx} = split_pos(cmd.pos_x);
    {cz, fz} = split_pos(cmd.pos_z);
    fsum     = {1'b0, fx} + {1'b0, fz};
    col_half[0] = HALF_W'((32'(cx) >> 1) + 32'(cx[0]));
    col_half[1] = HALF_W'(32'(cx) >> 1);
    row_half[0] = HALF_W'((32'(cz) >> 1) + 32'(cz[0]));
    row_half[1] = HALF_W'(32'(cz) >> 1);
    rd_addr[0]  = bank_addr(row_half[0], col_half[0]);
    rd_addr[1]  = bank_addr(row_half[0], col_half[1]);
    rd_addr[2]  = bank_addr(row_half[1], col_half[0]);
    rd_addr[3]  = bank_addr(row_half[1], col_half[1]);
  end

  logic              wr_en;
  logic [1:0]        wr_bank;
  logic [AW-1:0]     wr_addr;
  logic [SW-1:0]     wr_data;

  always_comb begin
    wr_en   = cmd_take && !is_query &&
              (32'(cmd.vert_col) <= 32'(GRID_CELLS)) &&
              (32'(cmd.vert_row) <= 32'(GRID_CELLS));
    wr_bank = {cmd.vert_row[0], cmd.vert_col[0]};
    wr_addr = bank_addr(HALF_W'(32'(cmd.vert_row) >> 1), HALF_W'(32'(cmd.vert_col) >> 1));
    wr_data = SW'(cmd.height_sample);
  end

  logic [BANKS-1:0][SW-1:0] rd_data;

  hmtri_store #(
    .GRID_CELLS  (GRID_CELLS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .BANK_SIDE   (BANK_SIDE),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_bank (wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (adv1),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // stage 1: corner data arrives from the store
  logic [FW-1:0] s1_fx, s1_fz;
  logic          s1_px, s1_pz, s1_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= cmd_take && is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_fx    <= fx;
      s1_fz    <= fz;
      s1_px    <= cx[0];
      s1_pz    <= cz[0];
      s1_lower <= (fsum <= {1'b0, FRAC_ONE});
    end
  end

  // stage 2: corner products
  logic [SW-1:0]        corner_a, corner_b, corner_c, corner_d, base;
  logic signed [SW:0]   e1, e2;
  logic signed [FW:0]   w1, w2;
  logic [SW-1:0]        s2_base;
  logic signed [P_W-1:0] s2_p1, s2_p2;
  logic                 s2_lower;

  always_comb begin
    corner_c = rd_data[{s1_pz, s1_px}];
    corner_d = rd_data[{s1_pz, !s1_px}];
    corner_a = rd_data[{!s1_pz, s1_px}];
    corner_b = rd_data[{!s1_pz, !s1_px}];
    if (s1_lower) begin
      base = corner_c;
      e1   = $signed({1'b0, corner_a}) - $signed({1'b0, corner_c});
      w1   = $signed({1'b0, s1_fz});
      e2   = $signed({1'b0, corner_d}) - $signed({1'b0, corner_c});
      w2   = $signed({1'b0, s1_fx});
    end else begin
      base = corner_b;
      e1   = $signed({1'b0, corner_d}) - $signed({1'b0, corner_b});
      w1   = $signed({1'b0, FRAC_ONE - s1_fz});
      e2   = $signed({1'b0, corner_a}) - $signed({1'b0, corner_b});
      w2   = $signed({1'b0, FRAC_ONE - s1_fx});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_base  <= base;
      s2_p1    <= e1 * w1;
      s2_p2    <= e2 * w2;
      s2_lower <= s1_lower;
    end
  end

  // stage 3: interpolated height
  logic signed [H_W-1:0] h_sum;
  logic [HU-1:0]         s3_h;
  logic                  s3_lower;

  assign h_sum = H_W'($signed({1'b0, s2_base, {FRAC_BITS{1'b0}}}))
               + H_W'(s2_p1) + H_W'(s2_p2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_h     <= h_sum[H_W-1] ? '0 : h_sum[HU-1:0];
      s3_lower <= s2_lower;
    end
  end

  // stage 4: scale product
  logic [HU+SCALE_W-1:0] s4_prod;
  logic                  s4_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_prod  <= s3_h * scale;
      s4_lower <= s3_lower;
    end
  end

  // stage 5: round half up, saturate, output register
  logic [HU+SCALE_W:0] rnd;
  logic [HU:0]         rq;
  logic [HEIGHT_W-1:0] s5_height;
  logic                s5_lower;

  always_comb begin
    rnd = {1'b0, s4_prod} + (HU + SCALE_W + 1)'(32'h8000);
    rq  = rnd[HU+SCALE_W:SCALE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv5) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      s5_height <= (32'(rq) > 32'hFFFF) ? {HEIGHT_W{1'b1}} : HEIGHT_W'(rq);
      s5_lower  <= s4_lower;
    end
  end

  assign rsp.valid          = s5_valid;
  assign rsp.height         = s5_height;
  assign rsp.lower_triangle = s5_lower;

endmodule

// File: rtl/core/hmtri_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the heightmap triangle height query block, with the bind
// that attaches them to the top level. Depends on hmtri_pkg.
module hmtri_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [hmtri_pkg::HEIGHT_W-1:0] rsp_height,
  input logic                           rsp_lower,
  input logic                           cfg_ready
);
  import hmtri_pkg::*;

  // output register held under backpressure
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_height) && $stable(rsp_lower))
    else $error("result changed while stalled");

  // pipeline never blocks input unless the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || rsp_ready) |-> cmd_ready)
    else $error("input blocked with output free");

  assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid && cfg_ready)
    else $error("result or config stall right after reset");

endmodule

bind heightmap_triangle_height_query hmtri_checker u_hmtri_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_height (rsp.height),
  .rsp_lower  (rsp.lower_triangle),
  .cfg_ready  (cfg.ready)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for heightmap_triangle_height_query: random sample loads and
// triangle-interpolated height queries, checked against an in-bench height predictor.
// Depends on hmtri_pkg, hmtri_if and the heightmap_triangle_height_query RTL.
module tb;
  import hmtri_pkg::*;

  localparam int GRID_CELLS = 64;
  localparam int FRAC_BITS  = 8;
  localparam int GRID_SIDE  = GRID_CELLS + 1;
  localparam int STORE_SIZE = GRID_SIDE * GRID_SIDE;
  localparam longint FRAC_ONE = 64'd1 << FRAC_BITS;

  typedef struct {
    func_t               func;
    logic [VERT_W-1:0]   col;
    logic [VERT_W-1:0]   row;
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    pz;
  } cmd_item_t;

  typedef struct {
    logic [HEIGHT_W-1:0] height;
    logic                lower;
  } height_result_t;

  logic clk = 1'b0;
  logic rst;

  hmtri_cmd_if cmd_ch ();
  hmtri_rsp_if rsp_ch ();
  hmtri_cfg_if cfg_ch ();

  heightmap_triangle_height_query dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  cmd_item_t      cmd_pending[$];
  height_result_t height_due[$];

  bit [SAMPLE_W-1:0] height_mem [0:STORE_SIZE-1];
  bit                sample_set [0:STORE_SIZE-1];
  bit [SCALE_W-1:0]  cur_scale = SCALE_RESET;

  int  send_idle_pct = 0;
  int  rsp_stall_pct = 0;
  int  pushed_cnt    = 0;
  int  taken_cnt     = 0;
  int  scale_writes  = 0;
  int  fails         = 0;
  logic cmd_took     = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void split_coord(input logic [POS_W-1:0] p, output int cell_idx,
                                      output longint frac);
    longint v;
    v = p;
    if (v > (longint'(GRID_CELLS) << FRAC_BITS)) v = longint'(GRID_CELLS) << FRAC_BITS;
    if ((v >> FRAC_BITS) >= GRID_CELLS) begin
      cell_idx = GRID_CELLS - 1;
      frac = FRAC_ONE;
    end else begin
      cell_idx = int'(v >> FRAC_BITS);
      frac = v & (FRAC_ONE - 1);
    end
  endfunction

  function automatic longint sample_at(input int row, input int col);
    return longint'(height_mem[row * GRID_SIDE + col]);
  endfunction

  function automatic height_result_t predict_height(input logic [POS_W-1:0] px,
                                                    input logic [POS_W-1:0] pz);
    height_result_t res;
    int cx, cz;
    longint fx, fz, a, b, c, d, h, s;
    split_coord(px, cx, fx);
    split_coord(pz, cz, fz);
    a = sample_at(cz + 1, cx);
    b = sample_at(cz + 1, cx + 1);
    c = sample_at(cz, cx);
    d = sample_at(cz, cx + 1);
    res.lower = (fx + fz) <= FRAC_ONE;
    if (res.lower)
      h = c * FRAC_ONE + (a - c) * fz + (d - c) * fx;
    else
      h = b * FRAC_ONE + (d - b) * (FRAC_ONE - fz) + (a - b) * (FRAC_ONE - fx);
    if (h < 0) h = 0;
    s = (h * longint'(cur_scale) + 64'h8000) >>> 16;
    if (s > 64'hFFFF) s = 64'hFFFF;
    res.height = s[HEIGHT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    cmd_item_t it;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_took) begin
      if (cmd_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = cmd_pending.pop_front();
        cmd_ch.valid         <= 1'b1;
        cmd_ch.func          <= it.func;
        cmd_ch.vert_col      <= it.col;
        cmd_ch.vert_row      <= it.row;
        cmd_ch.height_sample <= it.sample;
        cmd_ch.pos_x         <= it.px;
        cmd_ch.pos_z         <= it.pz;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    height_result_t want;
    cmd_took <= !rst && cmd_ch.valid && cmd_ch.ready;
    if (rst) begin
      cur_scale = SCALE_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cur_scale = cfg_ch.data;
        scale_writes++;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        taken_cnt++;
        if (func_t'(cmd_ch.func) == FUNC_WRITE) begin
          if (cmd_ch.vert_col <= GRID_CELLS && cmd_ch.vert_row <= GRID_CELLS)
            height_mem[cmd_ch.vert_row * GRID_SIDE + cmd_ch.vert_col] = cmd_ch.height_sample;
        end else begin
          height_due = {height_due, predict_height(cmd_ch.pos_x, cmd_ch.pos_z)};
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (height_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual height %0d lower %0b",
                   $time, rsp_ch.height, rsp_ch.lower_triangle);
          fails++;
        end else begin
          want = height_due.pop_front();
          if (rsp_ch.height !== want.height) begin
            $display("%0t: height expected %0d actual %0d", $time, want.height,
                     rsp_ch.height);
            fails++;
          end
          if (rsp_ch.lower_triangle !== want.lower) begin
            $display("%0t: lower_triangle expected %0b actual %0b", $time, want.lower,
                     rsp_ch.lower_triangle);
            fails++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void push_write(input int col, input int row, input int sample);
    cmd_item_t it;
    it.func   = FUNC_WRITE;
    it.col    = VERT_W'(col);
    it.row    = VERT_W'(row);
    it.sample = SAMPLE_W'(sample);
    it.px     = POS_W'($urandom);
    it.pz     = POS_W'($urandom);
    cmd_pending = {cmd_pending, it};
    pushed_cnt++;
    if (col <= GRID_CELLS && row <= GRID_CELLS) sample_set[row * GRID_SIDE + col] = 1'b1;
  endfunction

  function automatic void push_query(input int px, input int pz);
    cmd_item_t it;
    it.func   = FUNC_QUERY;
    it.col    = VERT_W'($urandom);
    it.row    = VERT_W'($urandom);
    it.sample = SAMPLE_W'($urandom);
    it.px     = POS_W'(px);
    it.pz     = POS_W'(pz);
    cmd_pending = {cmd_pending, it};
    pushed_cnt++;
  endfunction

  function automatic bit cell_ready(input int cx, input int cz);
    return sample_set[cz * GRID_SIDE + cx] && sample_set[cz * GRID_SIDE + cx + 1] &&
           sample_set[(cz + 1) * GRID_SIDE + cx] && sample_set[(cz + 1) * GRID_SIDE + cx + 1];
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_cell();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return GRID_CELLS - 1;
      default: return $urandom_range(0, GRID_CELLS - 1);
    endcase
  endfunction

  // query position inside cell (cx, cz); about one in eight lands on the diagonal
  function automatic void push_cell_query(input int cx, input int cz);
    int fx, fz;
    case ($urandom_range(0, 7))
      0: begin
        fx = $urandom_range(1, 255);
        fz = 256 - fx;
      end
      1: begin
        fx = $urandom_range(0, 1) * 255;
        fz = $urandom_range(0, 1) * 255;
      end
      default: begin
        fx = $urandom_range(0, 255);
        fz = $urandom_range(0, 255);
      end
    endcase
    push_query((cx << FRAC_BITS) | fx, (cz << FRAC_BITS) | fz);
  endfunction

  task automatic random_session(input int n_items);
    int counted, cx, cz, dx, dz, r, col, row;
    counted = 0;
    while (counted < n_items) begin
      r  = $urandom_range(0, 99);
      cx = pick_cell();
      cz = pick_cell();
      if (r < 65) begin
        for (dz = 0; dz < 2; dz++)
          for (dx = 0; dx < 2; dx++)
            if (!sample_set[(cz + dz) * GRID_SIDE + cx + dx] || $urandom_range(0, 3) == 0) begin
              push_write(cx + dx, cz + dz, pick_sample());
              counted++;
            end
        repeat ($urandom_range(1, 3)) begin
          push_cell_query(cx, cz);
          counted++;
        end
      end else if (r < 85 && cell_ready(cx, cz)) begin
        push_cell_query(cx, cz);
        counted++;
      end else begin
        if ($urandom_range(0, 1)) begin
          col = $urandom_range(0, GRID_CELLS);
          row = $urandom_range(0, GRID_CELLS);
        end else begin
          col = $urandom_range(0, 127);
          row = $urandom_range(0, 127);
        end
        push_write(col, row, $urandom_range(0, 255));
        if (col <= GRID_CELLS && row <= GRID_CELLS) counted++;
      end
    end
  endtask

  task automatic drain_pipe();
    while (pushed_cnt != taken_cnt || height_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    int seen;
    seen = scale_writes;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    while (scale_writes == seen) @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst                  = 1'b1;
    cmd_ch.valid         = 1'b0;
    cmd_ch.func          = FUNC_WRITE;
    cmd_ch.vert_col      = '0;
    cmd_ch.vert_row      = '0;
    cmd_ch.height_sample = '0;
    cmd_ch.pos_x         = '0;
    cmd_ch.pos_z         = '0;
    rsp_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    rsp_stall_pct = 50;

    // directed: corner cell, diagonal boundary, overwrite, ignored writes, far cell
    push_write(0, 0, 0);
    push_write(1, 0, 255);
    push_write(0, 1, 255);
    push_write(1, 1, 0);
    push_query(0, 0);
    push_query(255, 0);
    push_query(255, 1);
    push_query(255, 2);
    push_query(128, 128);
    push_query(255, 255);
    push_write(0, 0, 200);
    push_write(65, 0, 77);
    push_write(127, 127, 255);
    push_write(3, 100, 9);
    push_write(0, 65, 11);
    push_query(64, 32);
    push_write(63, 63, 255);
    push_write(64, 63, 128);
    push_write(63, 64, 1);
    push_write(64, 64, 255);
    push_query(16383, 16383);
    push_query(16128, 16383);
    push_query(16383, 16128);
    drain_pipe();

    write_scale(16'hFFFF);
    random_session(150);
    drain_pipe();
    write_scale(16'h0000);
    random_session(30);
    drain_pipe();

    send_idle_pct = 50;
    rsp_stall_pct = 34;
    write_scale(16'h0001);
    random_session(30);
    drain_pipe();
    write_scale(SCALE_W'($urandom));
    random_session(150);
    drain_pipe();

    send_idle_pct = 0;
    rsp_stall_pct = 0;
    write_scale(16'h8000);
    random_session(190);
    drain_pipe();

    if (fails == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
